// ----- sv/udrb_pkg.sv -----
// ----------------------------------------------------------------------------
// udrb_pkg
// Shared types and constants for the UART dual ring buffer.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package udrb_pkg;

   // Field widths
   localparam int DATA_W     = 8;
   localparam int REQ_W      = 3;
   localparam int RXC_W      = 8;
   localparam int TXP_W      = 9;
   localparam int CSR_IDX_W  = 1;
   localparam int CSR_DATA_W = 1;

   // Request codes
   localparam logic [REQ_W-1:0] REQ_RX_BYTE = 3'd0;
   localparam logic [REQ_W-1:0] REQ_HOST_WR = 3'd1;
   localparam logic [REQ_W-1:0] REQ_HOST_RD = 3'd2;
   localparam logic [REQ_W-1:0] REQ_DRE_EVT = 3'd3;
   localparam logic [REQ_W-1:0] REQ_FLUSH   = 3'd4;

   // Register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_RX_ENABLE = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_TX_ENABLE = 1'd1;

   // Controller to datapath commands
   typedef struct packed {
      logic latch_req;  // capture the request payload
      logic exec;       // apply ring updates, issue memory access
      logic resp;       // load the response register
   } ctrl_cmd_type;

   // Datapath to controller status
   typedef struct packed {
      logic out_full;   // response register holds an unsent result
   } dp_status_type;

endpackage

// ----- sv/udrb_req_if.sv -----
// ----------------------------------------------------------------------------
// udrb_req_if
// Request channel: valid/ready handshake with the request payload.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface udrb_req_if import udrb_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [REQ_W-1:0]  req_type;
   logic [DATA_W-1:0] data_byte;
   logic              hw_dre_flag;
   logic              hw_txc_flag;

   modport source (
      output valid, req_type, data_byte, hw_dre_flag, hw_txc_flag,
      input  ready
   );

   modport sink (
      input  valid, req_type, data_byte, hw_dre_flag, hw_txc_flag,
      output ready
   );
endinterface

// ----- sv/udrb_rsp_if.sv -----
// ----------------------------------------------------------------------------
// udrb_rsp_if
// Response channel: valid/ready handshake with the result payload.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface udrb_rsp_if import udrb_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [DATA_W-1:0] out_byte;
   logic              out_valid;
   logic              accepted;
   logic [RXC_W-1:0]  rx_count;
   logic [TXP_W-1:0]  tx_pending;
   logic              dre_irq_enable;

   modport source (
      output valid, out_byte, out_valid, accepted, rx_count, tx_pending,
             dre_irq_enable,
      input  ready
   );

   modport sink (
      input  valid, out_byte, out_valid, accepted, rx_count, tx_pending,
             dre_irq_enable,
      output ready
   );
endinterface

// ----- sv/udrb_ram.sv -----
// ----------------------------------------------------------------------------
// udrb_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module udrb_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // Registered read port
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- sv/udrb_ctrl.sv -----
// ----------------------------------------------------------------------------
// udrb_ctrl
// Sequencer: accept a request, execute it, then load the response.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module udrb_ctrl import udrb_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   output logic          req_ready,
   input  logic          rsp_ready,
   input  dp_status_type status,
   output ctrl_cmd_type  cmd
);

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_EXEC = 2'd1;
   localparam logic [1:0] ST_RESP = 2'd2;

   logic [1:0] state_ff;
   logic [1:0] state_in;
   logic       req_xfer;
   logic       slot_free;

   // A new request may enter while the previous one is being answered
   assign req_ready = (state_ff == ST_IDLE) || (state_ff == ST_RESP);
   assign req_xfer  = req_valid && req_ready;
   // Response register is empty, or is draining this cycle
   assign slot_free = !status.out_full || rsp_ready;

   // Next state and commands
   always_comb begin
      state_in      = state_ff;
      cmd.latch_req = req_xfer;
      cmd.exec      = 1'b0;
      cmd.resp      = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (req_xfer) begin
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: begin
            if (slot_free) begin
               cmd.exec = 1'b1;
               state_in = ST_RESP;
            end
         end
         ST_RESP: begin
            cmd.resp = 1'b1;
            state_in = req_xfer ? ST_EXEC : ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Checks
   a_exec_then_resp: assert property (@(posedge clock) disable iff (reset)
      cmd.exec |=> (state_ff == ST_RESP))
      else $error("execute not followed by response");

   a_exec_holds: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_EXEC && !slot_free) |=> (state_ff == ST_EXEC))
      else $error("left execute while response register busy");

endmodule

// ----- sv/udrb_dpath.sv -----
// ----------------------------------------------------------------------------
// udrb_dpath
// Ring pointers, ring memories, session registers and response register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module udrb_dpath import udrb_pkg::*; #(
   parameter int RING_DEPTH = 256
) (
   input  logic                  clock,
   input  logic                  reset,
   // register writes
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata,
   // sequencer
   input  ctrl_cmd_type          cmd,
   output dp_status_type         status,
   // request payload
   input  logic [REQ_W-1:0]      req_type,
   input  logic [DATA_W-1:0]     data_byte,
   input  logic                  hw_dre_flag,
   input  logic                  hw_txc_flag,
   // response
   input  logic                  rsp_ready,
   output logic                  rsp_valid,
   output logic [DATA_W-1:0]     out_byte,
   output logic                  out_valid,
   output logic                  accepted,
   output logic [RXC_W-1:0]      rx_count,
   output logic [TXP_W-1:0]      tx_pending,
   output logic                  dre_irq_enable
);

   localparam int PTR_W = $clog2(RING_DEPTH);
   localparam int CW    = (PTR_W > 9) ? PTR_W + 2 : 11;
   localparam logic [PTR_W-1:0] LAST_SLOT = PTR_W'(RING_DEPTH - 1);
   localparam logic [CW-1:0]    DEPTH_C   = CW'(RING_DEPTH);
   localparam logic [CW-1:0]    RXC_MAX   = CW'(255);
   localparam logic [CW-1:0]    TXP_MAX   = CW'(511);
   localparam logic [PTR_W:0]   DEPTH_P   = (PTR_W + 1)'(RING_DEPTH);

   function automatic logic [PTR_W-1:0] next_slot(input logic [PTR_W-1:0] p);
      return (p == LAST_SLOT) ? '0 : p + 1'b1;
   endfunction

   function automatic logic [CW-1:0] ring_count(input logic [PTR_W-1:0] wp,
                                                input logic [PTR_W-1:0] rp);
      logic [CW-1:0] w;
      logic [CW-1:0] r;
      w = CW'(wp);
      r = CW'(rp);
      return (wp >= rp) ? (w - r) : (w + DEPTH_C - r);
   endfunction

   // Session registers
   logic rx_en_ff;
   logic tx_en_ff;

   // Captured request
   logic [REQ_W-1:0]  req_code_ff;
   logic [DATA_W-1:0] data_ff;
   logic              dre_ff;
   logic              txc_ff;

   // Ring state
   logic [PTR_W-1:0] rx_wp_ff, rx_wp_in;
   logic [PTR_W-1:0] rx_rp_ff, rx_rp_in;
   logic [PTR_W-1:0] tx_wp_ff, tx_wp_in;
   logic [PTR_W-1:0] tx_rp_ff, tx_rp_in;
   logic             tx_begun_ff, tx_begun_in;
   logic             dre_en_ff, dre_en_in;

   // Execute results carried to the response cycle
   logic acc_ff, acc_in;
   logic pop_ff, pop_in;
   logic pop_tx_ff, pop_tx_in;

   // Response register
   logic              out_full_ff;
   logic [DATA_W-1:0] out_byte_ff;
   logic              out_valid_ff;
   logic              out_acc_ff;
   logic [RXC_W-1:0]  out_rxc_ff;
   logic [TXP_W-1:0]  out_txp_ff;
   logic              out_dre_ff;

   logic              rx_push, tx_push, rx_rd, tx_rd;
   logic              rx_full, rx_empty, tx_full, tx_empty;
   logic [DATA_W-1:0] rx_rd_data, tx_rd_data;
   logic [CW-1:0]     rxc_raw, txp_raw;
   logic [CW-1:0]     rxc_sat, txp_sat;

   // Session registers
   always_ff @(posedge clock) begin
      if (reset) begin
         rx_en_ff <= 1'b0;
         tx_en_ff <= 1'b0;
      end else if (csr_we) begin
         case (csr_index)
            CSR_RX_ENABLE: rx_en_ff <= csr_wdata[0];
            CSR_TX_ENABLE: tx_en_ff <= csr_wdata[0];
            default: ;
         endcase
      end
   end

   // Request capture
   always_ff @(posedge clock) begin
      if (cmd.latch_req) begin
         req_code_ff <= req_type;
         data_ff     <= data_byte;
         dre_ff      <= hw_dre_flag;
         txc_ff      <= hw_txc_flag;
      end
   end

   assign rx_full  = (next_slot(rx_wp_ff) == rx_rp_ff);
   assign rx_empty = (rx_wp_ff == rx_rp_ff);
   assign tx_full  = (next_slot(tx_wp_ff) == tx_rp_ff);
   assign tx_empty = (tx_wp_ff == tx_rp_ff);

   // Execute: ring updates and memory access
   always_comb begin
      rx_wp_in    = rx_wp_ff;
      rx_rp_in    = rx_rp_ff;
      tx_wp_in    = tx_wp_ff;
      tx_rp_in    = tx_rp_ff;
      tx_begun_in = tx_begun_ff;
      dre_en_in   = dre_en_ff;
      rx_push     = 1'b0;
      tx_push     = 1'b0;
      rx_rd       = 1'b0;
      tx_rd       = 1'b0;
      acc_in      = 1'b0;
      pop_in      = 1'b0;
      pop_tx_in   = 1'b0;
      if (cmd.exec) begin
         case (req_code_ff)
            REQ_RX_BYTE: begin
               if (!rx_full) begin
                  rx_push  = 1'b1;
                  rx_wp_in = next_slot(rx_wp_ff);
                  acc_in   = 1'b1;
               end
            end
            REQ_HOST_WR: begin
               if (tx_en_ff && !tx_full) begin
                  tx_push     = 1'b1;
                  tx_wp_in    = next_slot(tx_wp_ff);
                  acc_in      = 1'b1;
                  tx_begun_in = 1'b1;
                  dre_en_in   = 1'b1;
               end
            end
            REQ_HOST_RD: begin
               if (rx_en_ff && !rx_empty) begin
                  rx_rd    = 1'b1;
                  rx_rp_in = next_slot(rx_rp_ff);
                  pop_in   = 1'b1;
               end
            end
            REQ_DRE_EVT: begin
               if (!tx_empty) begin
                  tx_rd     = 1'b1;
                  tx_rp_in  = next_slot(tx_rp_ff);
                  pop_in    = 1'b1;
                  pop_tx_in = 1'b1;
               end else begin
                  dre_en_in = 1'b0;
               end
            end
            REQ_FLUSH: begin
               rx_wp_in    = '0;
               rx_rp_in    = '0;
               tx_wp_in    = '0;
               tx_rp_in    = '0;
               tx_begun_in = 1'b0;
            end
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rx_wp_ff    <= '0;
         rx_rp_ff    <= '0;
         tx_wp_ff    <= '0;
         tx_rp_ff    <= '0;
         tx_begun_ff <= 1'b0;
         dre_en_ff   <= 1'b0;
      end else begin
         rx_wp_ff    <= rx_wp_in;
         rx_rp_ff    <= rx_rp_in;
         tx_wp_ff    <= tx_wp_in;
         tx_rp_ff    <= tx_rp_in;
         tx_begun_ff <= tx_begun_in;
         dre_en_ff   <= dre_en_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.exec) begin
         acc_ff    <= acc_in;
         pop_ff    <= pop_in;
         pop_tx_ff <= pop_tx_in;
      end
   end

   // Ring memories
   udrb_ram #(.WIDTH(DATA_W), .DEPTH(RING_DEPTH)) u_rx_ram (
      .clock   (clock),
      .wr_en   (rx_push),
      .wr_addr (rx_wp_ff),
      .wr_data (data_ff),
      .rd_en   (rx_rd),
      .rd_addr (rx_rp_ff),
      .rd_data (rx_rd_data)
   );

   udrb_ram #(.WIDTH(DATA_W), .DEPTH(RING_DEPTH)) u_tx_ram (
      .clock   (clock),
      .wr_en   (tx_push),
      .wr_addr (tx_wp_ff),
      .wr_data (data_ff),
      .rd_en   (tx_rd),
      .rd_addr (tx_rp_ff),
      .rd_data (tx_rd_data)
   );

   // Status counts, taken after the update
   assign rxc_raw = ring_count(rx_wp_ff, rx_rp_ff);
   assign txp_raw = ring_count(tx_wp_ff, tx_rp_ff) + CW'(!dre_ff) + CW'(!txc_ff);
   assign rxc_sat = (rxc_raw > RXC_MAX) ? RXC_MAX : rxc_raw;
   assign txp_sat = (tx_en_ff && tx_begun_ff) ?
                    ((txp_raw > TXP_MAX) ? TXP_MAX : txp_raw) : '0;

   // Response register
   always_ff @(posedge clock) begin
      if (reset) begin
         out_full_ff <= 1'b0;
      end else if (cmd.resp) begin
         out_full_ff <= 1'b1;
      end else if (rsp_ready) begin
         out_full_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.resp) begin
         out_byte_ff  <= pop_ff ? (pop_tx_ff ? tx_rd_data : rx_rd_data) : '0;
         out_valid_ff <= pop_ff;
         out_acc_ff   <= acc_ff;
         out_rxc_ff   <= rxc_sat[RXC_W-1:0];
         out_txp_ff   <= txp_sat[TXP_W-1:0];
         out_dre_ff   <= dre_en_ff;
      end
   end

   assign status.out_full = out_full_ff;
   assign rsp_valid       = out_full_ff;
   assign out_byte        = out_byte_ff;
   assign out_valid       = out_valid_ff;
   assign accepted        = out_acc_ff;
   assign rx_count        = out_rxc_ff;
   assign tx_pending      = out_txp_ff;
   assign dre_irq_enable  = out_dre_ff;

   // Checks
   a_resp_slot_free: assert property (@(posedge clock) disable iff (reset)
      cmd.resp |-> !out_full_ff)
      else $error("response loaded over an unsent result");

   a_ptr_range: assert property (@(posedge clock) disable iff (reset)
      ({1'b0, rx_wp_ff} < DEPTH_P) && ({1'b0, rx_rp_ff} < DEPTH_P) &&
      ({1'b0, tx_wp_ff} < DEPTH_P) && ({1'b0, tx_rp_ff} < DEPTH_P))
      else $error("ring pointer beyond depth");

   a_push_or_pop: assert property (@(posedge clock) disable iff (reset)
      out_full_ff |-> !(out_valid_ff && out_acc_ff))
      else $error("result reports both a push and a pop");

endmodule

// ----- sv/uart_dual_ring_buffer.sv -----
// ----------------------------------------------------------------------------
// uart_dual_ring_buffer
// Flow: a request is captured, then executed (ring update and the ring
// RAM's registered read), then loaded into the response register. A new
// request may be taken while the previous one is answered; execute waits while the response register is held.
// Reset: synchronous; clears pointers, flags and session enables. Ring RAM
// contents stay undefined and need no clearing pass.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module uart_dual_ring_buffer import udrb_pkg::*; #(
   parameter int RING_DEPTH = 256
) (
   input  logic                  clock,
   input  logic                  reset,
   udrb_req_if.sink              req_chan,
   udrb_rsp_if.source            rsp_chan,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   ctrl_cmd_type  cmd;
   dp_status_type status;

   // Sequencer
   udrb_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_chan.ready),
      .rsp_ready (rsp_chan.ready),
      .status    (status),
      .cmd       (cmd)
   );

   // Rings and response
   udrb_dpath #(.RING_DEPTH(RING_DEPTH)) u_dpath (
      .clock          (clock),
      .reset          (reset),
      .csr_we         (csr_we),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata),
      .cmd            (cmd),
      .status         (status),
      .req_type       (req_chan.req_type),
      .data_byte      (req_chan.data_byte),
      .hw_dre_flag    (req_chan.hw_dre_flag),
      .hw_txc_flag    (req_chan.hw_txc_flag),
      .rsp_ready      (rsp_chan.ready),
      .rsp_valid      (rsp_chan.valid),
      .out_byte       (rsp_chan.out_byte),
      .out_valid      (rsp_chan.out_valid),
      .accepted       (rsp_chan.accepted),
      .rx_count       (rsp_chan.rx_count),
      .tx_pending     (rsp_chan.tx_pending),
      .dre_irq_enable (rsp_chan.dre_irq_enable)
   );

endmodule

// ----- tb/uart_dual_ring_buffer_test.sv -----
// ----------------------------------------------------------------------------
// uart_dual_ring_buffer_test
// Self-checking bench for the UART dual ring buffer. Requests go in from a
// queue through a valid/ready driver with random gaps. Responses are taken
// with random back-pressure, including one long hold-off that fills the
// block. Every accepted request runs through a local model of both rings.
// Each response is compared field by field with the oldest expected status.
// Directed cases come first, then random phases under several settings of
// the session enables.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module uart_dual_ring_buffer_test;
   import udrb_pkg::*;

   localparam int          RING_DEPTH        = 256;
   localparam int unsigned LONG_STALL_CYCLES = 300;
   localparam int unsigned WATCHDOG_LIMIT    = 2000;

   // Request codes the block treats as no-ops
   localparam logic [REQ_W-1:0] REQ_FIRST_UNUSED = REQ_FLUSH + 3'd1;
   localparam logic [REQ_W-1:0] REQ_LAST_CODE    = '1;

   typedef enum {IDLE_NONE, IDLE_SOME, IDLE_FULL} idle_type;

   typedef struct packed {
      logic [REQ_W-1:0]  kind;
      logic [DATA_W-1:0] data;
      logic              dre;
      logic              txc;
   } uart_req_type;

   typedef struct packed {
      logic [DATA_W-1:0] pop_data;
      logic              pop_valid;
      logic              push_ok;
      logic [RXC_W-1:0]  rx_fill;
      logic [TXP_W-1:0]  tx_pend;
      logic              dre_irq;
   } uart_rsp_type;

   logic                  clock;
   logic                  reset;
   logic                  csr_we;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_wdata;

   udrb_req_if req_if ();
   udrb_rsp_if rsp_if ();

   uart_dual_ring_buffer u_top (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req_if),
      .rsp_chan  (rsp_if),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   // Stimulus and scoreboard
   uart_req_type queued_requests[$];
   uart_rsp_type expected_status[$];
   int unsigned  mismatches = 0;
   idle_type     idle_mode = IDLE_NONE;
   logic         stall_ask = 1'b0;
   logic         stall_started = 1'b0;
   int unsigned  stall_left = 0;
   int unsigned  req_gap = 0;
   int unsigned  rsp_gap = 0;
   int unsigned  quiet_cycles = 0;
   logic         req_taken;
   logic         rsp_taken;

   // Local copy of both rings, flags and session enables
   logic [DATA_W-1:0] rx_ring [RING_DEPTH];
   logic [DATA_W-1:0] tx_ring [RING_DEPTH];
   int unsigned       rx_wr, rx_rd, tx_wr, tx_rd;
   logic              tx_begun, dre_on;
   logic              cfg_rx_en, cfg_tx_en;

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   function automatic int unsigned draw_gap();
      case (idle_mode)
         IDLE_NONE: return 0;
         IDLE_SOME: return ($urandom_range(0, 3) == 0) ? $urandom_range(0, 11) : 0;
         default:   return $urandom_range(0, 11);
      endcase
   endfunction

   // Apply one request to the ring model and return the status it reports
   function automatic uart_rsp_type ring_step(uart_req_type r);
      uart_rsp_type o;
      int unsigned  nx;
      int unsigned  cnt;
      o = '0;
      case (r.kind)
         REQ_RX_BYTE: begin
            // received bytes are pushed whatever the receive enable holds
            nx = (rx_wr + 1) % RING_DEPTH;
            if (nx != rx_rd) begin
               rx_ring[rx_wr] = r.data;
               rx_wr = nx;
               o.push_ok = 1'b1;
            end
         end
         REQ_HOST_WR: begin
            nx = (tx_wr + 1) % RING_DEPTH;
            if (cfg_tx_en && nx != tx_rd) begin
               tx_ring[tx_wr] = r.data;
               tx_wr = nx;
               o.push_ok = 1'b1;
               tx_begun = 1'b1;
               dre_on = 1'b1;
            end
         end
         REQ_HOST_RD: begin
            if (cfg_rx_en && rx_rd != rx_wr) begin
               o.pop_data = rx_ring[rx_rd];
               o.pop_valid = 1'b1;
               rx_rd = (rx_rd + 1) % RING_DEPTH;
            end
         end
         REQ_DRE_EVT: begin
            // acts regardless of the interrupt enable; empty ring clears it
            if (tx_rd != tx_wr) begin
               o.pop_data = tx_ring[tx_rd];
               o.pop_valid = 1'b1;
               tx_rd = (tx_rd + 1) % RING_DEPTH;
            end else begin
               dre_on = 1'b0;
            end
         end
         REQ_FLUSH: begin
            rx_wr = 0;
            rx_rd = 0;
            tx_wr = 0;
            tx_rd = 0;
            tx_begun = 1'b0;
         end
         default: ;
      endcase
      cnt = (rx_wr + RING_DEPTH - rx_rd) % RING_DEPTH;
      o.rx_fill = cnt[RXC_W-1:0];
      if (cfg_tx_en && tx_begun) begin
         cnt = (tx_wr + RING_DEPTH - tx_rd) % RING_DEPTH;
         if (!r.dre) cnt++;
         if (!r.txc) cnt++;
         o.tx_pend = cnt[TXP_W-1:0];
      end
      o.dre_irq = dre_on;
      return o;
   endfunction

   function automatic uart_req_type random_request(int w_rx, int w_wr, int w_rd, int w_dre,
                                                   int w_fl, int w_junk);
      uart_req_type r;
      int           pick;
      pick = $urandom_range(0, w_rx + w_wr + w_rd + w_dre + w_fl + w_junk - 1);
      r.data = DATA_W'($urandom_range(0, 255));
      r.dre = 1'($urandom_range(0, 1));
      r.txc = 1'($urandom_range(0, 1));
      if (pick < w_rx) r.kind = REQ_RX_BYTE;
      else if (pick < w_rx + w_wr) r.kind = REQ_HOST_WR;
      else if (pick < w_rx + w_wr + w_rd) r.kind = REQ_HOST_RD;
      else if (pick < w_rx + w_wr + w_rd + w_dre) r.kind = REQ_DRE_EVT;
      else if (pick < w_rx + w_wr + w_rd + w_dre + w_fl) r.kind = REQ_FLUSH;
      else r.kind = REQ_W'($urandom_range(REQ_FIRST_UNUSED, REQ_LAST_CODE));
      return r;
   endfunction

   task automatic check_field(string name, int unsigned want, int unsigned got);
      if (want != got) begin
         $error("%s mismatch: expected %0d, actual %0d", name, want, got);
         mismatches++;
      end
   endtask

   // Request driver: presents queued requests with random gaps
   always @(negedge clock) begin : request_driver
      uart_req_type nxt;
      if (!reset) begin
         if (req_taken) req_gap = draw_gap();
         if (!req_if.valid || req_taken) begin
            if (req_gap != 0) begin
               req_gap--;
               req_if.valid <= 1'b0;
            end else if (queued_requests.size() != 0) begin
               nxt = queued_requests.pop_front();
               req_if.valid       <= 1'b1;
               req_if.req_type    <= nxt.kind;
               req_if.data_byte   <= nxt.data;
               req_if.hw_dre_flag <= nxt.dre;
               req_if.hw_txc_flag <= nxt.txc;
            end else begin
               req_if.valid <= 1'b0;
            end
         end
      end
   end

   // Response sink: random back-pressure plus one long hold-off on request
   always @(negedge clock) begin : response_sink
      logic rdy;
      if (!reset) begin
         if (rsp_taken) rsp_gap = draw_gap();
         if (stall_ask && !stall_started) begin
            stall_started = 1'b1;
            stall_left = LONG_STALL_CYCLES;
         end
         if (stall_left != 0) begin
            stall_left--;
            rdy = 1'b0;
         end else if (rsp_gap != 0) begin
            rsp_gap--;
            rdy = 1'b0;
         end else begin
            rdy = 1'b1;
         end
         rsp_if.ready <= rdy;
      end
   end

   // Monitor: register writes, request transfers, response checks, watchdog
   always @(posedge clock) begin : monitor
      uart_req_type acc;
      uart_rsp_type want;
      logic         req_xfer;
      logic         rsp_xfer;
      req_xfer = req_if.valid && req_if.ready;
      rsp_xfer = rsp_if.valid && rsp_if.ready;
      if (reset) begin
         rx_wr = 0;
         rx_rd = 0;
         tx_wr = 0;
         tx_rd = 0;
         tx_begun = 1'b0;
         dre_on = 1'b0;
         cfg_rx_en = 1'b0;
         cfg_tx_en = 1'b0;
         req_taken <= 1'b0;
         rsp_taken <= 1'b0;
      end else begin
         if (csr_we) begin
            case (csr_index)
               CSR_RX_ENABLE: cfg_rx_en = csr_wdata[0];
               CSR_TX_ENABLE: cfg_tx_en = csr_wdata[0];
               default: ;
            endcase
         end
         if (rsp_xfer) begin
            if (expected_status.size() == 0) begin
               $error("response transfer with no expected status pending");
               mismatches++;
            end else begin
               want = expected_status.pop_front();
               check_field("out_byte", 32'(want.pop_data), 32'(rsp_if.out_byte));
               check_field("out_valid", 32'(want.pop_valid), 32'(rsp_if.out_valid));
               check_field("accepted", 32'(want.push_ok), 32'(rsp_if.accepted));
               check_field("rx_count", 32'(want.rx_fill), 32'(rsp_if.rx_count));
               check_field("tx_pending", 32'(want.tx_pend), 32'(rsp_if.tx_pending));
               check_field("dre_irq_enable", 32'(want.dre_irq),
                           32'(rsp_if.dre_irq_enable));
            end
         end
         if (req_xfer) begin
            acc.kind = req_if.req_type;
            acc.data = req_if.data_byte;
            acc.dre  = req_if.hw_dre_flag;
            acc.txc  = req_if.hw_txc_flag;
            expected_status.push_back(ring_step(acc));
         end
         req_taken <= req_xfer;
         rsp_taken <= rsp_xfer;
         if (req_xfer || rsp_xfer) begin
            quiet_cycles = 0;
         end else begin
            quiet_cycles++;
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
               $display("FAIL");
               $finish;
            end
         end
      end
   end

   task automatic add_request(logic [REQ_W-1:0] kind, logic [DATA_W-1:0] data,
                              logic dre, logic txc);
      uart_req_type r;
      r.kind = kind;
      r.data = data;
      r.dre  = dre;
      r.txc  = txc;
      queued_requests.push_back(r);
   endtask

   // Block is idle once nothing is queued, offered or outstanding
   task automatic wait_idle();
      do @(posedge clock);
      while (queued_requests.size() != 0 || req_if.valid || expected_status.size() != 0);
      repeat (2) @(negedge clock);
   endtask

   task automatic write_csr(logic [CSR_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] val);
      @(negedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(negedge clock);
      csr_we    <= 1'b0;
   endtask

   task automatic run_phase(logic rx_en, logic tx_en, int n, int w_rx, int w_wr,
                            int w_rd, int w_dre, int w_fl, int w_junk,
                            idle_type mode, logic long_stall);
      wait_idle();
      write_csr(CSR_RX_ENABLE, rx_en);
      write_csr(CSR_TX_ENABLE, tx_en);
      idle_mode = mode;
      if (long_stall) stall_ask = 1'b1;
      for (int i = 0; i < n; i++)
         queued_requests.push_back(random_request(w_rx, w_wr, w_rd, w_dre, w_fl, w_junk));
   endtask

   // Main sequence
   initial begin
      reset              = 1'b1;
      csr_we             = 1'b0;
      csr_index          = '0;
      csr_wdata          = '0;
      req_if.valid       = 1'b0;
      req_if.req_type    = '0;
      req_if.data_byte   = '0;
      req_if.hw_dre_flag = 1'b0;
      req_if.hw_txc_flag = 1'b0;
      rsp_if.ready       = 1'b0;
      repeat (3) @(negedge clock);
      reset <= 1'b0;

      // Both sessions closed (reset values): host reads and writes do nothing
      add_request(REQ_RX_BYTE, 8'h00, 1'b0, 1'b0);
      add_request(REQ_RX_BYTE, 8'hFF, 1'b1, 1'b1);
      add_request(REQ_HOST_RD, 8'h00, 1'b0, 1'b0);
      add_request(REQ_HOST_WR, 8'h3C, 1'b0, 1'b1);
      add_request(REQ_DRE_EVT, 8'h00, 1'b1, 1'b0);
      add_request(REQ_FIRST_UNUSED, 8'hFF, 1'b0, 1'b0);
      add_request(REQ_LAST_CODE, 8'h00, 1'b1, 1'b1);

      // Both sessions open: round trips, empty pops, flush
      wait_idle();
      write_csr(CSR_RX_ENABLE, 1'b1);
      write_csr(CSR_TX_ENABLE, 1'b1);
      add_request(REQ_HOST_RD, 8'h00, 1'b1, 1'b1);
      add_request(REQ_HOST_WR, 8'hA5, 1'b0, 1'b0);
      add_request(REQ_HOST_WR, 8'h5A, 1'b1, 1'b0);
      add_request(REQ_DRE_EVT, 8'h00, 1'b0, 1'b1);
      add_request(REQ_DRE_EVT, 8'h00, 1'b1, 1'b1);
      add_request(REQ_DRE_EVT, 8'h00, 1'b0, 1'b0);
      add_request(REQ_HOST_RD, 8'h00, 1'b0, 1'b0);
      add_request(REQ_HOST_RD, 8'h00, 1'b1, 1'b0);
      add_request(REQ_HOST_WR, 8'h81, 1'b0, 1'b0);
      add_request(REQ_RX_BYTE, 8'h7E, 1'b1, 1'b0);
      add_request(REQ_FLUSH, 8'h00, 1'b0, 1'b0);
      add_request(REQ_FIRST_UNUSED + 3'd1, 8'h00, 1'b0, 1'b1);
      add_request(REQ_HOST_RD, 8'h00, 1'b1, 1'b1);
      add_request(REQ_DRE_EVT, 8'h00, 1'b0, 1'b0);

      // Random phases: mixed traffic, fill to full under a long hold-off,
      // drain, then the remaining enable settings
      run_phase(1'b1, 1'b1, 150, 25, 25, 20, 20, 3, 7, IDLE_FULL, 1'b0);
      run_phase(1'b1, 1'b1, 550, 48, 48, 2, 2, 0, 0, IDLE_SOME, 1'b1);
      run_phase(1'b1, 1'b1, 450, 4, 4, 45, 45, 0, 2, IDLE_NONE, 1'b0);
      run_phase(1'b0, 1'b1, 120, 25, 30, 20, 20, 2, 3, IDLE_FULL, 1'b0);
      run_phase(1'b1, 1'b0, 120, 25, 30, 20, 20, 2, 3, IDLE_SOME, 1'b0);
      run_phase(1'b0, 1'b0, 100, 25, 25, 20, 20, 3, 7, IDLE_FULL, 1'b0);

      wait_idle();
      repeat (8) @(posedge clock);
      if (mismatches == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule
